// ===== hdl/byte_stack_array_macros.svh =====
// Assertion helpers, used by bsa_ctrl.
`ifndef BYTE_STACK_ARRAY_MACROS_SVH
`define BYTE_STACK_ARRAY_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define BSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/bsa_pkg.sv =====
package bsa_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int WORD_BYTES   = 4;
  localparam int OFF_W        = $clog2(WORD_BYTES);

  localparam int TYPE_W    = 3;
  localparam int POS_W     = 11;
  localparam int DATA_W    = 32;
  localparam int FILL_W    = 11;
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 48;

  typedef enum logic [TYPE_W-1:0] {
    REQ_PUSH_BYTE = 3'd0,
    REQ_POP_BYTE  = 3'd1,
    REQ_PUSH_WORD = 3'd2,
    REQ_POP_WORD  = 3'd3,
    REQ_GET       = 3'd4,
    REQ_SET       = 3'd5,
    REQ_CLEAR     = 3'd6,
    REQ_RESIZE    = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESP
  } state_t;

  // per-bank access strobe and write byte
  typedef struct packed {
    logic       we;
    logic       re;
    logic [7:0] wdata;
  } bank_req_t;

endpackage

// ===== hdl/byte_stack_array.sv =====
// byte_stack_array: byte stack with indexed access over four byte-interleaved banks.
// Result word: bank read registered at accept, then the out reg loads in the response state,
// which waits while m_tvalid is high and m_tready low; no new word is taken before that load.
// Reset (rst, sync, active high) clears the fill level, then sweeps all banks to zero,
// one row per cycle over ceil(CAPACITY/4) rows (256 at default) with s_tready low.
module byte_stack_array #(
  parameter int CAPACITY = bsa_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata from bit 0: req_type[3], position[11], data_value[32], zero pad[2]
  input  logic [bsa_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata from bit 0: read_data[32], ok[1], fill_level[11], zero pad[4]
  output logic [bsa_pkg::M_TDATA_W-1:0] m_tdata
);
  import bsa_pkg::*;

  // byte i lives in bank i%4, row i/4
  localparam int DEPTH = (CAPACITY + WORD_BYTES - 1) / WORD_BYTES;
  localparam int ROW_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [TYPE_W-1:0] req_type;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] data_value;
  logic [DATA_W-1:0] read_data;
  logic              ok;
  logic [FILL_W-1:0] fill_level;

  bank_req_t         bank_req   [WORD_BYTES];
  logic [ROW_W-1:0]  bank_addr  [WORD_BYTES];
  logic [7:0]        bank_rdata [WORD_BYTES];

  // unpack the input word
  assign req_type   = s_tdata[TYPE_W-1:0];
  assign position   = s_tdata[TYPE_W +: POS_W];
  assign data_value = s_tdata[TYPE_W+POS_W +: DATA_W];

  // pack the result word
  assign m_tdata = {{(M_TDATA_W-DATA_W-1-FILL_W){1'b0}}, fill_level, ok, read_data};

  bsa_ctrl #(
    .CAPACITY (CAPACITY),
    .ROW_W    (ROW_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .req_type   (req_type),
    .position   (position),
    .data_value (data_value),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .read_data  (read_data),
    .ok         (ok),
    .fill_level (fill_level),
    .bank_req   (bank_req),
    .bank_addr  (bank_addr),
    .bank_rdata (bank_rdata)
  );

  // four byte banks; a word at any offset touches each bank once
  for (genvar b = 0; b < WORD_BYTES; b++) begin : g_bank
    bsa_bank #(
      .DEPTH  (DEPTH),
      .ADDR_W (ROW_W)
    ) u_bank (
      .clk   (clk),
      .req   (bank_req[b]),
      .addr  (bank_addr[b]),
      .rdata (bank_rdata[b])
    );
  end

endmodule

// ===== hdl/bsa_bank.sv =====
module bsa_bank #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  bsa_pkg::bank_req_t req,
  input  logic [ADDR_W-1:0] addr,
  output logic [7:0]        rdata
);
  import bsa_pkg::*;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hdl/bsa_ctrl.sv =====
`include "byte_stack_array_macros.svh"

module bsa_ctrl #(
  parameter int CAPACITY = bsa_pkg::CAPACITY_DEF,
  parameter int ROW_W    = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [bsa_pkg::TYPE_W-1:0]   req_type,
  input  logic [bsa_pkg::POS_W-1:0]    position,
  input  logic [bsa_pkg::DATA_W-1:0]   data_value,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [bsa_pkg::DATA_W-1:0]   read_data,
  output logic                         ok,
  output logic [bsa_pkg::FILL_W-1:0]   fill_level,
  output bsa_pkg::bank_req_t           bank_req  [bsa_pkg::WORD_BYTES],
  output logic [ROW_W-1:0]             bank_addr [bsa_pkg::WORD_BYTES],
  input  logic [7:0]                   bank_rdata [bsa_pkg::WORD_BYTES]
);
  import bsa_pkg::*;

  localparam int DEPTH = (CAPACITY + WORD_BYTES - 1) / WORD_BYTES;
  localparam int LVL_W = $clog2(CAPACITY + 1);
  localparam int CW    = ((LVL_W > POS_W) ? LVL_W : POS_W) + 1;

  state_t            state, state_next;
  logic [LVL_W-1:0]  level, level_next;
  logic [ROW_W-1:0]  clr_row;
  logic              clr_done;
  logic              accept;
  logic              out_load;
  logic              ok_c;
  logic              do_wr, do_rd, is_word;
  logic [LVL_W-1:0]  base;
  logic [CW-1:0]     lvl_x, pos_x, cap_x;
  req_t              kind;
  req_t              r_kind;
  logic              r_ok;
  logic [OFF_W-1:0]  r_off;
  logic [DATA_W-1:0] rd_c;

  assign kind     = req_t'(req_type);
  assign lvl_x    = CW'(level);
  assign pos_x    = CW'(position);
  assign cap_x    = CW'(CAPACITY);
  assign accept   = s_tvalid && s_tready;
  assign clr_done = (clr_row == ROW_W'(DEPTH - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_done) state_next = ST_IDLE;
      ST_IDLE:  if (accept)   state_next = ST_RESP;
      ST_RESP:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_CLEAR: ;
      ST_IDLE:  s_tready = 1'b1;
      ST_RESP:  out_load = !m_tvalid || m_tready;
      default:  ;
    endcase
  end

  // request decode
  always_comb begin
    ok_c       = 1'b0;
    level_next = level;
    base       = level;
    do_wr      = 1'b0;
    do_rd      = 1'b0;
    is_word    = 1'b0;
    unique case (kind)
      REQ_PUSH_BYTE: begin
        if (lvl_x < cap_x) begin
          ok_c       = 1'b1;
          do_wr      = 1'b1;
          level_next = LVL_W'(lvl_x + CW'(1));
        end
      end
      REQ_POP_BYTE: begin
        base = LVL_W'(lvl_x - CW'(1));
        if (level != '0) begin
          ok_c       = 1'b1;
          do_rd      = 1'b1;
          level_next = base;
        end
      end
      REQ_PUSH_WORD: begin
        is_word = 1'b1;
        if (lvl_x + CW'(WORD_BYTES) <= cap_x) begin
          ok_c       = 1'b1;
          do_wr      = 1'b1;
          level_next = LVL_W'(lvl_x + CW'(WORD_BYTES));
        end
      end
      REQ_POP_WORD: begin
        is_word = 1'b1;
        base    = LVL_W'(lvl_x - CW'(WORD_BYTES));
        if (lvl_x >= CW'(WORD_BYTES)) begin
          ok_c       = 1'b1;
          do_rd      = 1'b1;
          level_next = base;
        end
      end
      REQ_GET: begin
        base = LVL_W'(pos_x);
        if (pos_x < lvl_x) begin
          ok_c  = 1'b1;
          do_rd = 1'b1;
        end
      end
      REQ_SET: begin
        base = LVL_W'(pos_x);
        if (pos_x < lvl_x) begin
          ok_c  = 1'b1;
          do_wr = 1'b1;
        end
      end
      REQ_CLEAR: begin
        ok_c       = 1'b1;
        level_next = '0;
      end
      REQ_RESIZE: begin
        if (pos_x <= cap_x) begin
          ok_c       = 1'b1;
          level_next = LVL_W'(pos_x);
        end
      end
      default: ;
    endcase
  end

  // lane steering: bank b holds byte base+k where k = (b - base) mod 4
  always_comb begin
    logic [OFF_W-1:0] k;
    logic [LVL_W-1:0] idx;
    for (int b = 0; b < WORD_BYTES; b++) begin
      k   = OFF_W'(b) - base[OFF_W-1:0];
      idx = LVL_W'(base + LVL_W'(k));
      if (state == ST_CLEAR) begin
        bank_addr[b]      = clr_row;
        bank_req[b].we    = 1'b1;
        bank_req[b].re    = 1'b0;
        bank_req[b].wdata = 8'h00;
      end else begin
        bank_addr[b]      = idx[ROW_W+OFF_W-1:OFF_W];
        bank_req[b].we    = accept && do_wr && (is_word || k == '0);
        bank_req[b].re    = accept && do_rd;
        bank_req[b].wdata = data_value[{k, 3'b000} +: 8];
      end
    end
  end

  // result assembly from registered bank data
  always_comb begin
    logic [DATA_W-1:0] word;
    for (int k = 0; k < WORD_BYTES; k++) begin
      word[8*k +: 8] = bank_rdata[OFF_W'(r_off + OFF_W'(k))];
    end
    rd_c = '0;
    if (r_ok) begin
      case (r_kind) inside
        REQ_POP_WORD:          rd_c = word;
        REQ_POP_BYTE, REQ_GET: rd_c = {{(DATA_W-8){1'b0}}, word[7:0]};
        default:               rd_c = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      level    <= '0;
      clr_row  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR && !clr_done) begin
        clr_row <= ROW_W'(clr_row + 1'b1);
      end
      if (accept) begin
        level <= level_next;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_kind <= kind;
      r_ok   <= ok_c;
      r_off  <= base[OFF_W-1:0];
    end
    if (out_load) begin
      read_data  <= rd_c;
      ok         <= r_ok;
      fill_level <= FILL_W'(lvl_x);
    end
  end

  `BSA_ASSERT_NOW(a_level_cap, 1'b1, lvl_x <= cap_x, "fill level above capacity")
  `BSA_ASSERT_NEXT(a_accept_resp, accept, state == ST_RESP, "accepted word did not enter response")
  `BSA_ASSERT_NEXT(a_reject_hold, accept && !ok_c, $stable(level), "rejected request moved level")
  `BSA_ASSERT_NOW(a_resp_no_wr, state == ST_RESP, !bank_req[0].we && !bank_req[WORD_BYTES-1].we, "bank write outside accept")

endmodule
